>>> rtl/core/pkbd_pkg.sv
// pkbd_pkg: shared types and constants of the packbits decompressor
// depends on nothing; used by every module of the block

package pkbd_pkg;

	// byte lanes in one output word
	localparam int OUT_BYTES  = 8;
	localparam int BYTE_W     = 8;
	localparam int BUF_W      = OUT_BYTES * BYTE_W;
	// fill level and lane counts, must hold OUT_BYTES itself
	localparam int FILL_W     = $clog2(OUT_BYTES + 1);
	// repeat count of one command, up to 128
	localparam int CNT_W      = 8;
	localparam int TOTAL_W    = 32;
	localparam int WORD_W     = 64;
	localparam int BCNT_W     = 4;
	// command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// packed stream widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 104;

	// control byte codes
	localparam logic [BYTE_W-1:0] CTRL_NOP = 8'h80;

	typedef enum logic [1:0] {
		MODE_CONTROL,
		MODE_LITERAL,
		MODE_RUN
	} mode_t;

	// one command: write value count times, then close the strip if last
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic [CNT_W-1:0]  count;
		logic              last;
	} cmd_t;

endpackage

>>> rtl/core/pkbd_front.sv
// pkbd_front: accepts compressed bytes and turns them into byte-repeat commands
// depends on pkbd_pkg

module pkbd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                data_byte,
	input  logic                      strip_end,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic                      cmd_push,
	output pkbd_pkg::cmd_t            cmd,
	input  logic                      cmd_full
);
	import pkbd_pkg::*;

	mode_t              mode_q, mode_nxt;
	logic [CNT_W-1:0]   remaining_q, remaining_nxt;
	logic               accept;

	assign in_ready = !cmd_full;
	assign accept   = in_valid && in_ready;

	// next state
	always_comb begin
		mode_nxt      = mode_q;
		remaining_nxt = remaining_q;
		if (accept) begin
			unique case (mode_q)
				MODE_LITERAL: begin
					remaining_nxt = remaining_q - CNT_W'(1);
					if (remaining_q == CNT_W'(1)) begin
						mode_nxt = MODE_CONTROL;
					end
				end
				MODE_RUN: begin
					remaining_nxt = '0;
					mode_nxt      = MODE_CONTROL;
				end
				default: begin
					if (data_byte < CTRL_NOP) begin
						mode_nxt      = MODE_LITERAL;
						remaining_nxt = data_byte + CNT_W'(1);
					end else if (data_byte != CTRL_NOP) begin
						mode_nxt      = MODE_RUN;
						remaining_nxt = CNT_W'(9'd257 - {1'b0, data_byte});
					end
				end
			endcase
			// strip end drops any pending literal or run
			if (strip_end) begin
				mode_nxt      = MODE_CONTROL;
				remaining_nxt = '0;
			end
		end
	end

	// outputs
	always_comb begin
		cmd.value = data_byte;
		cmd.last  = strip_end;
		unique case (mode_q)
			MODE_LITERAL: cmd.count = CNT_W'(1);
			MODE_RUN:     cmd.count = remaining_q;
			default:      cmd.count = '0;
		endcase
		cmd_push = accept && ((mode_q != MODE_CONTROL) || strip_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CONTROL;
			remaining_q <= '0;
		end else begin
			mode_q      <= mode_nxt;
			remaining_q <= remaining_nxt;
		end
	end

endmodule

>>> rtl/core/pkbd_cmdq.sv
// pkbd_cmdq: short command queue between front and back
// depends on pkbd_pkg

module pkbd_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pkbd_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output pkbd_pkg::cmd_t pop_cmd,
	output logic           empty
);
	import pkbd_pkg::*;

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CMDQ_CNT_W'(1);
				2'b01:   count_q <= count_q - CMDQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/pkbd_back.sv
// pkbd_back: carries out repeat commands, packs bytes into words, closes strips
// depends on pkbd_pkg

module pkbd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_empty,
	input  pkbd_pkg::cmd_t                   cmd,
	output logic                             cmd_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pkbd_pkg::WORD_W-1:0]      out_word,
	output logic [pkbd_pkg::BCNT_W-1:0]      byte_count,
	output logic                             strip_last,
	output logic [pkbd_pkg::TOTAL_W-1:0]     strip_total
);
	import pkbd_pkg::*;

	// active command
	logic                busy_q;
	logic [BYTE_W-1:0]   value_q;
	logic [CNT_W-1:0]    left_q;
	logic                end_q;
	// packing state
	logic [BUF_W-1:0]    buf_q;
	logic [FILL_W-1:0]   fill_q;
	logic [TOTAL_W-1:0]  total_q;
	// output register
	logic                ovalid_q;
	logic [WORD_W-1:0]   oword_q;
	logic [BCNT_W-1:0]   ocount_q;
	logic                olast_q;
	logic [TOTAL_W-1:0]  ototal_q;

	logic [FILL_W-1:0]   room;
	logic [FILL_W-1:0]   take;
	logic [FILL_W-1:0]   fill_sum;
	logic [BUF_W-1:0]    merged;
	logic                out_free;
	logic                step;
	logic                have_bytes;
	logic                word_full;
	logic                done;

	assign out_free   = !ovalid_q || out_ready;
	assign step       = busy_q && out_free;
	assign have_bytes = (left_q != '0);
	assign room       = FILL_W'(OUT_BYTES) - fill_q;
	assign take       = (left_q < CNT_W'(room)) ? FILL_W'(left_q) : room;
	assign fill_sum   = fill_q + take;
	assign word_full  = have_bytes && (fill_sum == FILL_W'(OUT_BYTES));
	assign done       = step && (have_bytes ? ((left_q == CNT_W'(take)) && !end_q) : 1'b1);
	assign cmd_pop    = !cmd_empty && (!busy_q || done);

	// fill the free lanes up to this step's byte count with the value
	always_comb begin
		for (int k = 0; k < OUT_BYTES; k++) begin
			if ((FILL_W'(k) >= fill_q) && (FILL_W'(k) < fill_sum)) begin
				merged[k*BYTE_W +: BYTE_W] = value_q;
			end else begin
				merged[k*BYTE_W +: BYTE_W] = buf_q[k*BYTE_W +: BYTE_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			buf_q    <= '0;
			fill_q   <= '0;
			total_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (step && (word_full || !have_bytes)) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (step) begin
				if (have_bytes) begin
					total_q <= total_q + TOTAL_W'(take);
					if (word_full) begin
						buf_q  <= '0;
						fill_q <= '0;
					end else begin
						buf_q  <= merged;
						fill_q <= fill_sum;
					end
				end else begin
					buf_q   <= '0;
					fill_q  <= '0;
					total_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			value_q <= cmd.value;
			left_q  <= cmd.count;
			end_q   <= cmd.last;
		end else if (step && have_bytes) begin
			left_q <= left_q - CNT_W'(take);
		end
		if (step) begin
			if (word_full) begin
				oword_q  <= WORD_W'(merged);
				ocount_q <= BCNT_W'(OUT_BYTES);
				olast_q  <= 1'b0;
				ototal_q <= '0;
			end else if (!have_bytes) begin
				oword_q  <= WORD_W'(buf_q);
				ocount_q <= BCNT_W'(fill_q);
				olast_q  <= 1'b1;
				ototal_q <= total_q;
			end
		end
	end

	assign out_valid   = ovalid_q;
	assign out_word    = oword_q;
	assign byte_count  = ocount_q;
	assign strip_last  = olast_q;
	assign strip_total = ototal_q;

endmodule

>>> rtl/core/packbits_decompressor.sv
// packbits_decompressor: top level of the packbits run-length decoder
// depends on pkbd_pkg, pkbd_front, pkbd_cmdq, pkbd_back
//
// usage
//   slave stream: one compressed byte per item in s_tdata, s_tlast marks the
//   last compressed byte of a strip
//   master stream: one item per packed word; m_tdata carries the word, the
//   number of valid lanes and, on the item with m_tlast, the strip's total
//   of unpacked bytes; non-final items always carry a full word
// throughput
//   the front takes one byte per cycle while the command queue has room;
//   each literal byte and each control byte is one accepted item
//   the back writes a run of value bytes into as many lanes as are free in
//   one cycle while the output register can take a word, and that
//   per-cycle lane fill sets the rate for long runs
//   closing a strip takes an extra back step for the final item
// output path
//   a byte that completes a word passes the command queue, the command load
//   in the back and the back output register before it shows on m_tdata
// reset and stall
//   arst_n clears the decode mode, queue, packing buffer and strip total;
//   a stalled m_tready holds the output register, the back stops, the queue
//   fills and then s_tready drops

module packbits_decompressor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pkbd_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] data_byte
	input  logic                               s_tlast,   // strip_end
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pkbd_pkg::OUT_DATA_W-1:0]    m_tdata,   // [63:0] out_word,
	                                                      // [67:64] byte_count,
	                                                      // [99:68] strip_total
	output logic                               m_tlast    // strip_last
);
	import pkbd_pkg::*;

	cmd_t                push_cmd;
	cmd_t                pop_cmd;
	logic                cmd_push;
	logic                cmd_pop;
	logic                cmd_full;
	logic                cmd_empty;
	logic [WORD_W-1:0]   out_word;
	logic [BCNT_W-1:0]   byte_count;
	logic [TOTAL_W-1:0]  strip_total;

	// front: classifies control, literal and run bytes
	pkbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata[7:0]),
		.strip_end (s_tlast),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd_push  (cmd_push),
		.cmd       (push_cmd),
		.cmd_full  (cmd_full)
	);

	// queue lets the front keep taking bytes while the back works off a run
	pkbd_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.pop_cmd  (pop_cmd),
		.empty    (cmd_empty)
	);

	// back: packs bytes into words and closes strips
	pkbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmd_empty),
		.cmd         (pop_cmd),
		.cmd_pop     (cmd_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_word    (out_word),
		.byte_count  (byte_count),
		.strip_last  (m_tlast),
		.strip_total (strip_total)
	);

	// pack result fields, padded to whole bytes
	assign m_tdata = {4'b0000, strip_total, byte_count, out_word};

endmodule

>>> rtl/core/pkbd_checker.sv
// pkbd_checker: port-level assertions for packbits_decompressor, with its bind
// depends on pkbd_pkg and the top level's ports

module pkbd_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [pkbd_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            m_tlast
);
	import pkbd_pkg::*;

	// a word that does not close a strip is always full and carries no total
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[67:64] == BCNT_W'(OUT_BYTES))
			&& (m_tdata[99:68] == '0))
		else $error("non-final item not a full word");

	// lane count never exceeds the word
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[67:64] <= BCNT_W'(OUT_BYTES)))
		else $error("byte count out of range");

	// an empty final item carries an all-zero word
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && (m_tdata[67:64] == '0) |-> (m_tdata[63:0] == '0))
		else $error("empty final item has nonzero data");

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

endmodule

bind packbits_decompressor pkbd_checker u_pkbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
